FILE: rtl/wmft_pkg.sv
// Shared types and constants for the window mode frequency tracker.
package wmft_pkg;

	// Fixed field widths of the transactions
	localparam int unsigned ValueW = 10;
	localparam int unsigned FieldW = 13;

	// Item operation codes
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [ValueW-1:0] value;
	} item_t;

	typedef struct packed {
		logic [FieldW-1:0] max_frequency;
		logic [FieldW-1:0] min_parts;
		logic              rejected;
	} result_t;

endpackage

FILE: rtl/window_mode_frequency_tracker_unit.sv
// Top level of the window mode frequency tracker: count and histogram memories with sequencer.

// The block keeps a multiset window of values in two single-port-pair memories: a count per
// value and a histogram of how many values share each count. An item inserts or removes one
// value and yields one result with the highest count, the split figure and a reject flag.
// Each item goes from acceptance to its result in the output register through one read
// of the value count memory, then a read-modify-write of the old count's histogram bin and
// one of the new count's bin, then the result stage; the next item is taken once the result
// has moved to the output register, whether or not that register has been taken yet, so no
// new item is taken while one is in flight. A result held by result_stall keeps the
// following item waiting in the result stage.
// After reset a clearing pass writes zero to both memories, stepping through addresses up to
// max(VALUE_COUNT, WINDOW_CAPACITY + 1) - 1 (4096 at the defaults), during which item_stall
// stays high.
module window_mode_frequency_tracker_unit
	import wmft_pkg::*;
#(
	parameter int unsigned VALUE_COUNT     = 1024,
	parameter int unsigned WINDOW_CAPACITY = 4096
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int unsigned VW      = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
	localparam int unsigned HDEPTH  = WINDOW_CAPACITY + 1;
	localparam int unsigned CW      = $clog2(HDEPTH);
	localparam int unsigned CLR_LEN = (VALUE_COUNT > HDEPTH) ? VALUE_COUNT : HDEPTH;
	localparam int unsigned CLRW    = $clog2(CLR_LEN + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_H1   = 5'b00010,
		S_H2   = 5'b00100,
		S_H3   = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;

	// clearing pass counter
	logic [CLRW-1:0] clr_q;
	logic            clearing;

	// item and working registers
	item_t         item_q;
	logic          ok_q;
	logic          rej_q;
	logic [CW-1:0] c_q;
	logic [CW-1:0] cn_q;
	logic          hc_one_q;
	logic [CW-1:0] top_q;
	logic [CW-1:0] len_q;

	// output register
	result_t out_q;
	logic    out_valid_q;

	// memory ports
	logic          vc_we;
	logic [VW-1:0] vc_waddr;
	logic [CW-1:0] vc_wdata;
	logic [VW-1:0] vc_raddr;
	logic [CW-1:0] vc_rdata;
	logic          h_we;
	logic [CW-1:0] h_waddr;
	logic [CW-1:0] h_wdata;
	logic [CW-1:0] h_raddr;
	logic [CW-1:0] h_rdata;

	logic [CW-1:0] vc_mem [VALUE_COUNT];
	logic [CW-1:0] h_mem [HDEPTH];

	logic accept;
	logic out_free;
	logic is_insert;
	logic rej_now;

	logic [CW:0] half_len;
	logic [CW:0] diff;
	logic [CW:0] parts;

	assign clearing   = (clr_q != CLRW'(CLR_LEN));
	assign item_stall = clearing || (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;
	assign is_insert  = (item_q.mode == MODE_INSERT);

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// reject decision once the value's count is known
	always_comb begin
		if (!ok_q) begin
			rej_now = 1'b1;
		end else if (is_insert) begin
			rej_now = (len_q >= CW'(WINDOW_CAPACITY));
		end else begin
			rej_now = (vc_rdata == '0);
		end
	end

	// value count memory port control
	always_comb begin
		vc_raddr = VW'(item.value);
		vc_we    = 1'b0;
		vc_waddr = VW'(item_q.value);
		vc_wdata = cn_q;
		if (clearing) begin
			vc_we    = (clr_q < CLRW'(VALUE_COUNT));
			vc_waddr = clr_q[VW-1:0];
			vc_wdata = '0;
		end else if (state_q == S_H2) begin
			vc_we = !rej_q;
		end
	end

	// histogram memory port control: old bin in S_H2, new bin in S_H3
	always_comb begin
		h_raddr = (state_q == S_H1) ? vc_rdata : cn_q;
		h_we    = 1'b0;
		h_waddr = c_q;
		h_wdata = (h_rdata != '0) ? (h_rdata - CW'(1)) : h_rdata;
		if (clearing) begin
			h_we    = (clr_q < CLRW'(HDEPTH));
			h_waddr = clr_q[CW-1:0];
			h_wdata = '0;
		end else if (state_q == S_H2) begin
			h_we = !rej_q;
		end else if (state_q == S_H3) begin
			h_we    = !rej_q;
			h_waddr = cn_q;
			h_wdata = h_rdata + CW'(1);
		end
	end

	// value count memory
	always_ff @(posedge clk) begin
		if (vc_we) begin
			vc_mem[vc_waddr] <= vc_wdata;
		end
		vc_rdata <= vc_mem[vc_raddr];
	end

	// histogram memory
	always_ff @(posedge clk) begin
		if (h_we) begin
			h_mem[h_waddr] <= h_wdata;
		end
		h_rdata <= h_mem[h_raddr];
	end

	// split figure from the updated highest count and length
	always_comb begin
		half_len = ({1'b0, len_q} + (CW+1)'(1)) >> 1;
		diff     = {top_q, 1'b0} - {1'b0, len_q};
		parts    = (half_len >= {1'b0, top_q}) ? (CW+1)'(1) : diff;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			ok_q   <= (32'(item.value) < 32'(VALUE_COUNT));
		end
		if (state_q == S_H1) begin
			c_q   <= vc_rdata;
			cn_q  <= is_insert ? (vc_rdata + CW'(1)) : (vc_rdata - CW'(1));
			rej_q <= rej_now;
		end
		if (state_q == S_H2) begin
			hc_one_q <= (h_rdata == CW'(1));
		end
		if ((state_q == S_OUT) && out_free) begin
			out_q.max_frequency <= FieldW'(top_q);
			out_q.min_parts     <= FieldW'(parts);
			out_q.rejected      <= rej_q;
		end
	end

	// sequencer, clearing counter, window state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_q       <= '0;
			top_q       <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + CLRW'(1);
			end
			// output valid: set when a result loads, cleared when taken
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_H1;
					end
				end
				S_H1: state_q <= S_H2;
				S_H2: state_q <= S_H3;
				S_H3: begin
					if (!rej_q) begin
						if (is_insert) begin
							len_q <= len_q + CW'(1);
							if (cn_q > top_q) begin
								top_q <= cn_q;
							end
						end else begin
							len_q <= len_q - CW'(1);
							if ((c_q == top_q) && hc_one_q) begin
								top_q <= cn_q;
							end
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/wmft_checker.sv
// Port-level checker for the window mode frequency tracker and its bind.
module wmft_checker
	import wmft_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// split figure is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.min_parts != '0))
		else $error("split figure is zero");

	// an empty window reports a split figure of one
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.max_frequency == '0) |-> (result.min_parts == FieldW'(1)))
		else $error("empty window split figure wrong");

	// one transaction in flight: block is busy right after accepting one
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while busy");

endmodule

bind window_mode_frequency_tracker_unit wmft_checker u_wmft_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
